[rtl/vda_pkg.sv]
package vda_pkg;

    // register map (word index = paddr[4:2])
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = 5;

    localparam logic [REG_IDX_W-1:0] REG_NEEDS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SAT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CRIT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PT_A  = 3'd4;

    localparam logic        RST_NEEDS = 1'b1;
    localparam logic [14:0] RST_SAT   = 15'd11776;
    localparam logic [14:0] RST_BASE  = 15'd2560;
    localparam logic [13:0] RST_CRIT  = 14'd1229;

    localparam logic [16:0] FACTOR_ONE = 17'h10000;
    localparam logic [14:0] DAYS_MAX   = 15'h7FFF;

    // shared divider: 32-bit dividend, 16-bit divisor, 16-bit quotient
    localparam int DIV_W     = 16;
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic        needs;
        logic [14:0] sat;
        logic [14:0] base;
        logic [13:0] crit;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [2*DIV_W-1:0] num;
        logic [DIV_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic idle;
        logic div_wait;
    } core_stat_t;

    typedef struct packed {
        logic [14:0] vern_rate;
        logic [16:0] dev_factor;
        logic [14:0] vern_days;
        logic        vernalised;
        logic        forced;
        logic [15:0] completion_day;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOKUP,
        ST_MUL,
        ST_IDIV_GO,
        ST_IDIV,
        ST_FACTOR,
        ST_FDIV,
        ST_UPDATE,
        ST_OUT
    } st_t;

endpackage

[rtl/vda_regs.sv]
module vda_regs #(
    parameter int TABLE_POINTS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vda_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output vda_pkg::cfg_t                   cfg,
    output logic [TABLE_POINTS-1:0][31:0]   points
);
    import vda_pkg::*;

    logic                          needs_reg;
    logic [14:0]                   sat_reg;
    logic [14:0]                   base_reg;
    logic [13:0]                   crit_reg;
    logic [TABLE_POINTS-1:0][31:0] pt_reg;
    logic [REG_IDX_W-1:0]          idx;
    logic                          wr;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needs_reg <= RST_NEEDS;
            sat_reg   <= RST_SAT;
            base_reg  <= RST_BASE;
            crit_reg  <= RST_CRIT;
            pt_reg    <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_NEEDS: needs_reg <= pwdata[0];
                REG_SAT:   sat_reg   <= pwdata[14:0];
                REG_BASE:  base_reg  <= pwdata[14:0];
                REG_CRIT:  crit_reg  <= pwdata[13:0];
                default:
                begin
                    for (int i = 0; i < TABLE_POINTS; i++)
                    begin
                        if (idx == REG_PT_A + REG_IDX_W'(i))
                        begin
                            pt_reg[i] <= pwdata;
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_NEEDS: prdata = {31'd0, needs_reg};
            REG_SAT:   prdata = {17'd0, sat_reg};
            REG_BASE:  prdata = {17'd0, base_reg};
            REG_CRIT:  prdata = {18'd0, crit_reg};
            default:
            begin
                for (int i = 0; i < TABLE_POINTS; i++)
                begin
                    if (idx == REG_PT_A + REG_IDX_W'(i))
                    begin
                        prdata = pt_reg[i];
                    end
                end
            end
        endcase
    end

    assign cfg.needs = needs_reg;
    assign cfg.sat   = sat_reg;
    assign cfg.base  = base_reg;
    assign cfg.crit  = crit_reg;
    assign points    = pt_reg;

endmodule

[rtl/vda_div.sv]
module vda_div (
    input  logic              clk,
    input  logic              rst_n,
    input  vda_pkg::div_req_t req,
    output vda_pkg::div_rsp_t rsp
);
    import vda_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] low_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // one restoring step per cycle; dividend high half is below the divisor
    assign trial = {rem_reg, low_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num[2*DIV_W-1:DIV_W];
            low_reg <= req.num[DIV_W-1:0];
            den_reg <= req.den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            low_reg <= {low_reg[DIV_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

endmodule

[rtl/vda_core.sv]
module vda_core #(
    parameter int TABLE_POINTS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           mode,
    input  logic signed [14:0]             temperature,
    input  logic [13:0]                    dev_stage,
    input  logic [15:0]                    day_number,
    input  vda_pkg::cfg_t                  cfg,
    input  logic [TABLE_POINTS-1:0][31:0]  points,
    output vda_pkg::div_req_t              div_req,
    input  vda_pkg::div_rsp_t              div_rsp,
    input  logic                           res_ready,
    output logic                           res_valid,
    output vda_pkg::res_t                  res,
    output vda_pkg::core_stat_t            stat
);
    import vda_pkg::*;

    st_t state_reg, state_next;

    // latched item
    logic               mode_reg;
    logic signed [14:0] temp_reg;
    logic [13:0]        stage_reg;
    logic [15:0]        dayin_reg;

    // season state
    logic [14:0] acc_reg;
    logic        vern_reg;
    logic [16:0] held_reg;
    logic [15:0] day_reg;

    // per-item work registers
    logic        forced_reg;
    logic [14:0] rate_out_reg;
    logic [15:0] rtab_reg;
    logic [15:0] y0_reg;
    logic        dir_reg;
    logic [15:0] dy_reg;
    logic [15:0] dt_reg;
    logic [15:0] dx_reg;
    logic [31:0] prod_reg;

    // table lookup
    logic signed [15:0] pt_x [TABLE_POINTS];
    logic [15:0]        pt_y [TABLE_POINTS];
    logic signed [15:0] t16;
    logic               found;
    logic signed [15:0] seg_x0, seg_x1;
    logic [15:0]        seg_y0, seg_y1;
    logic               lk_direct;
    logic [15:0]        lk_y;
    logic               lk_dir;
    logic [15:0]        lk_dy;
    logic [16:0]        dt_wide, dx_wide;

    // factor and update
    logic        fct_direct;
    logic [16:0] fct_val;
    logic [14:0] fct_diff;
    logic [14:0] fct_den;
    logic [16:0] rnd;
    logic [14:0] remain;
    logic [15:0] rate_w;
    logic [16:0] sum;
    logic [14:0] acc_new;

    assign t16 = {temp_reg[14], temp_reg};

    always_comb
    begin
        for (int i = 0; i < TABLE_POINTS; i++)
        begin
            pt_x[i] = signed'(points[i][31:16]);
            pt_y[i] = points[i][15:0];
        end
    end

    // first point above the temperature closes the segment
    always_comb
    begin
        found  = 1'b0;
        seg_x0 = pt_x[0];
        seg_x1 = pt_x[0];
        seg_y0 = pt_y[0];
        seg_y1 = pt_y[0];
        for (int i = 1; i < TABLE_POINTS; i++)
        begin
            if (!found && (t16 < pt_x[i]))
            begin
                found  = 1'b1;
                seg_x0 = pt_x[i-1];
                seg_x1 = pt_x[i];
                seg_y0 = pt_y[i-1];
                seg_y1 = pt_y[i];
            end
        end
    end

    always_comb
    begin
        lk_direct = 1'b1;
        lk_y      = seg_y0;
        if (t16 <= pt_x[0])
        begin
            lk_y = pt_y[0];
        end
        else if (!found)
        begin
            lk_y = pt_y[TABLE_POINTS-1];
        end
        else if (t16 <= seg_x0)
        begin
            lk_y = seg_y0;
        end
        else
        begin
            lk_direct = 1'b0;
        end
    end

    assign lk_dir  = seg_y1 >= seg_y0;
    assign lk_dy   = lk_dir ? (seg_y1 - seg_y0) : (seg_y0 - seg_y1);
    assign dt_wide = {t16[15], t16} - {seg_x0[15], seg_x0};
    assign dx_wide = {seg_x1[15], seg_x1} - {seg_x0[15], seg_x0};

    // factor from the state before the day's addition
    always_comb
    begin
        fct_direct = 1'b1;
        fct_val    = '0;
        if (cfg.sat <= cfg.base)
        begin
            fct_val = (acc_reg >= cfg.sat) ? FACTOR_ONE : 17'd0;
        end
        else if (acc_reg <= cfg.base)
        begin
            fct_val = 17'd0;
        end
        else if (acc_reg >= cfg.sat)
        begin
            fct_val = FACTOR_ONE;
        end
        else
        begin
            fct_direct = 1'b0;
        end
    end

    assign fct_diff = acc_reg - cfg.base;
    assign fct_den  = cfg.sat - cfg.base;

    // Q1.15 -> Q8.8 round half up; forced rate is remaining plus one LSB
    assign rnd     = {1'b0, rtab_reg} + 17'd64;
    assign remain  = (cfg.sat > acc_reg) ? (cfg.sat - acc_reg) : 15'd0;
    assign rate_w  = forced_reg ? ({1'b0, remain} + 16'd1) : {6'd0, rnd[16:7]};
    assign sum     = {2'b00, acc_reg} + {1'b0, rate_w};
    assign acc_new = (sum > {2'b00, DAYS_MAX}) ? DAYS_MAX : sum[14:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!mode_reg || vern_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (stage_reg >= cfg.crit)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:  state_next = lk_direct ? ST_FACTOR : ST_MUL;
            ST_MUL:     state_next = ST_IDIV_GO;
            ST_IDIV_GO: state_next = ST_IDIV;
            ST_IDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FACTOR;
                end
            end
            ST_FACTOR:  state_next = fct_direct ? ST_UPDATE : ST_FDIV;
            ST_FDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        div_req       = '0;
        res_valid     = 1'b0;
        stat.idle     = 1'b0;
        stat.div_wait = 1'b0;
        case (state_reg)
            ST_IDLE:    stat.idle = 1'b1;
            ST_IDIV_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = prod_reg;
                div_req.den   = dx_reg;
            end
            ST_IDIV:    stat.div_wait = 1'b1;
            ST_FACTOR:
            begin
                div_req.start = !fct_direct;
                div_req.num   = {1'b0, fct_diff, 16'd0};
                div_req.den   = {1'b0, fct_den};
            end
            ST_FDIV:    stat.div_wait = 1'b1;
            ST_OUT:     res_valid = 1'b1;
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            vern_reg  <= !RST_NEEDS;
            held_reg  <= FACTOR_ONE;
            day_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_DISPATCH:
                begin
                    if (!mode_reg)
                    begin
                        acc_reg  <= '0;
                        vern_reg <= !cfg.needs;
                        held_reg <= FACTOR_ONE;
                        day_reg  <= '0;
                    end
                    else if (vern_reg)
                    begin
                        held_reg <= FACTOR_ONE;
                    end
                end
                ST_FACTOR:
                begin
                    if (fct_direct)
                    begin
                        held_reg <= fct_val;
                    end
                end
                ST_FDIV:
                begin
                    if (div_rsp.done)
                    begin
                        held_reg <= {1'b0, div_rsp.quo};
                    end
                end
                ST_UPDATE:
                begin
                    acc_reg <= acc_new;
                    if (acc_new >= cfg.sat)
                    begin
                        vern_reg <= 1'b1;
                        day_reg  <= dayin_reg;
                    end
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_reg  <= mode;
                    temp_reg  <= temperature;
                    stage_reg <= dev_stage;
                    dayin_reg <= day_number;
                end
            end
            ST_DISPATCH:
            begin
                rate_out_reg <= '0;
                forced_reg   <= mode_reg && !vern_reg && (stage_reg >= cfg.crit);
            end
            ST_LOOKUP:
            begin
                rtab_reg <= lk_y;
                y0_reg   <= seg_y0;
                dir_reg  <= lk_dir;
                dy_reg   <= lk_dy;
                dt_reg   <= dt_wide[15:0];
                dx_reg   <= dx_wide[15:0];
            end
            ST_MUL:     prod_reg <= dy_reg * dt_reg;
            ST_IDIV:
            begin
                if (div_rsp.done)
                begin
                    rtab_reg <= dir_reg ? (y0_reg + div_rsp.quo) : (y0_reg - div_rsp.quo);
                end
            end
            ST_UPDATE:  rate_out_reg <= rate_w[14:0];
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign res.vern_rate      = rate_out_reg;
    assign res.dev_factor     = held_reg;
    assign res.vern_days      = acc_reg;
    assign res.vernalised     = vern_reg;
    assign res.forced         = forced_reg;
    assign res.completion_day = day_reg;

endmodule

[rtl/vernalisation_day_accumulator.sv]
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+------------------------------------------
// in      | input     | in_valid / in_stall     | mode, temperature, dev_stage, day_number
// out     | output    | out_valid / out_stall   | vern_rate, dev_factor, vern_days,
//         |           |                         | vernalised, forced, completion_day
// cfg     | input     | psel / penable / pwrite | paddr, pwdata, prdata (pready tied high)
//
// Season start or vernalised day: dispatch, then result; forced day: dispatch, update, result.
// Normal day: table lookup and up to two 16-step passes through the shared divider
// (table interpolation, then the development factor) plus a multiply, then the update.
// Reset clears the season state (flag follows the needs_vernalisation reset value).
// One transaction in flight; in_stall is high until the result enters the output
// register, which can hold a result under out_stall while the next item is accepted.
module vernalisation_day_accumulator #(
    parameter int TABLE_POINTS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic signed [14:0]          temperature,
    input  logic [13:0]                 dev_stage,
    input  logic [15:0]                 day_number,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [14:0]                 vern_rate,
    output logic [16:0]                 dev_factor,
    output logic [14:0]                 vern_days,
    output logic                        vernalised,
    output logic                        forced,
    output logic [15:0]                 completion_day,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vda_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import vda_pkg::*;

    cfg_t                          cfg;
    logic [TABLE_POINTS-1:0][31:0] points;
    div_req_t                      div_req;
    div_rsp_t                      div_rsp;
    core_stat_t                    core_stat;
    res_t                          res;
    logic                          res_valid;
    logic                          res_ready;
    logic                          in_take;

    logic out_valid_reg;
    res_t out_res_reg;

    vda_regs #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .points  (points)
    );

    // shared divider, used for interpolation and for the factor
    vda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    vda_core #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_take),
        .mode        (mode),
        .temperature (temperature),
        .dev_stage   (dev_stage),
        .day_number  (day_number),
        .cfg         (cfg),
        .points      (points),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .res         (res),
        .stat        (core_stat)
    );

    assign in_stall  = !core_stat.idle;
    assign in_take   = in_valid && !in_stall;

    // output register: load when empty or when the held transaction leaves
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign vern_rate      = out_res_reg.vern_rate;
    assign dev_factor     = out_res_reg.dev_factor;
    assign vern_days      = out_res_reg.vern_days;
    assign vernalised     = out_res_reg.vernalised;
    assign forced         = out_res_reg.forced;
    assign completion_day = out_res_reg.completion_day;

    // a forced day always completes the requirement
    a_forced_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && forced |-> vernalised)
        else $error("forced day without completion");

    // the divider is never restarted mid-run
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // quotient arrives only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> core_stat.div_wait)
        else $error("divider result not expected");

    // an accepted transaction holds off the next one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("second transaction accepted while busy");

endmodule
